### hw/rtl/rgb_to_hsv_8bit_defines.svh
// Assertion macros for the RGB to HSV converter.
`ifndef RGB_TO_HSV_8BIT_DEFINES_SVH
`define RGB_TO_HSV_8BIT_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define RTHSV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset.
`define RTHSV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/rthsv_pkg.sv
package rthsv_pkg;

    localparam int PIX_W      = 8;    // channel width
    localparam int NUM_W      = 16;   // dividend width, holds 255 * 255
    localparam int QUO_W      = 8;    // quotient bits, one divider step each
    localparam int HUE_STEP   = 43;
    localparam int HUE_BASE_G = 85;
    localparam int HUE_BASE_B = 171;
    localparam int FULL_SCALE = 255;

    // which channel holds the maximum
    localparam logic [1:0] SEL_R = 2'd0;
    localparam logic [1:0] SEL_G = 2'd1;
    localparam logic [1:0] SEL_B = 2'd2;

    typedef struct packed {
        logic [1:0] sel;       // max channel code
        logic       neg;       // hue offset is negative
        logic       hue_zero;  // chroma is zero, hue forced to zero
    } hue_side_t;

endpackage

### hw/rtl/rthsv_front.sv
module rthsv_front
    import rthsv_pkg::*;
(
    input  logic             aclk,
    input  logic [1:0]       en,          // per-stage load enables
    input  logic [PIX_W-1:0] red,
    input  logic [PIX_W-1:0] green,
    input  logic [PIX_W-1:0] blue,
    output logic [NUM_W-1:0] sat_num,
    output logic [PIX_W-1:0] sat_den,     // value, also carried as result
    output logic [NUM_W-1:0] hue_num,
    output logic [PIX_W-1:0] hue_den,     // chroma
    output hue_side_t        hue_side
);

    // stage 1: max / min, channel difference
    logic [PIX_W-1:0] hi_next, lo_next, chroma_next, absd_next;
    logic [1:0]       sel_next;
    logic [PIX_W:0]   diff;
    logic             neg_next;

    logic [PIX_W-1:0] hi_reg, chroma_reg, absd_reg;
    logic [1:0]       sel_reg;
    logic             neg_reg;

    // stage 2: scaled numerators
    logic [NUM_W-1:0] sat_num_reg, hue_num_reg;
    logic [PIX_W-1:0] hi2_reg, chroma2_reg;
    hue_side_t        side_reg;

    always_comb begin
        // red wins ties, then green
        if (red >= green && red >= blue) begin
            sel_next = SEL_R;
            hi_next  = red;
            diff     = {1'b0, green} - {1'b0, blue};
        end else if (green >= blue) begin
            sel_next = SEL_G;
            hi_next  = green;
            diff     = {1'b0, blue} - {1'b0, red};
        end else begin
            sel_next = SEL_B;
            hi_next  = blue;
            diff     = {1'b0, red} - {1'b0, green};
        end
        lo_next = red;
        if (green < lo_next) lo_next = green;
        if (blue < lo_next) lo_next = blue;
        chroma_next = hi_next - lo_next;
        neg_next    = diff[PIX_W];
        absd_next   = neg_next ? PIX_W'(-diff) : diff[PIX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            hi_reg     <= hi_next;
            chroma_reg <= chroma_next;
            sel_reg    <= sel_next;
            neg_reg    <= neg_next;
            absd_reg   <= absd_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            // 255 * chroma as (chroma << 8) - chroma
            sat_num_reg <= NUM_W'({chroma_reg, {PIX_W{1'b0}}})
                         - NUM_W'(chroma_reg);
            hue_num_reg <= NUM_W'(absd_reg) * NUM_W'(HUE_STEP);
            hi2_reg     <= hi_reg;
            chroma2_reg <= chroma_reg;
            side_reg    <= '{sel: sel_reg, neg: neg_reg,
                             hue_zero: (chroma_reg == '0)};
        end
    end

    assign sat_num  = sat_num_reg;
    assign sat_den  = hi2_reg;
    assign hue_num  = hue_num_reg;
    assign hue_den  = chroma2_reg;
    assign hue_side = side_reg;

endmodule

### hw/rtl/rthsv_div.sv
// Pipelined restoring divider, one quotient bit per stage, MSB first.
// Requires num < den * 2**QUO_W.
module rthsv_div
    import rthsv_pkg::*;
#(
    parameter int QUO_W_P = QUO_W,
    parameter int NUM_W_P = NUM_W,
    parameter int DEN_W_P = PIX_W,
    parameter int SIDE_W  = 1
) (
    input  logic               aclk,
    input  logic [QUO_W_P-1:0] en,
    input  logic [NUM_W_P-1:0] num,
    input  logic [DEN_W_P-1:0] den,
    input  logic [SIDE_W-1:0]  side_in,
    output logic [QUO_W_P-1:0] quo,
    output logic [SIDE_W-1:0]  side_out
);

    localparam int CW = NUM_W_P + QUO_W_P;

    logic [NUM_W_P-1:0] rem_reg  [QUO_W_P];
    logic [DEN_W_P-1:0] den_reg  [QUO_W_P];
    logic [QUO_W_P-1:0] quo_reg  [QUO_W_P];
    logic [SIDE_W-1:0]  side_reg [QUO_W_P];

    for (genvar k = 0; k < QUO_W_P; k++) begin : g_step
        logic [NUM_W_P-1:0] rem_in;
        logic [DEN_W_P-1:0] den_in;
        logic [QUO_W_P-1:0] quo_in;
        logic [SIDE_W-1:0]  side_i;
        logic [CW-1:0]      shd;
        logic [CW-1:0]      remx;
        logic               ge;

        if (k == 0) begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
            assign side_i = side_in;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign side_i = side_reg[k-1];
        end

        assign shd  = CW'(den_in) << (QUO_W_P - 1 - k);
        assign remx = CW'(rem_in);
        assign ge   = (remx >= shd);

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                rem_reg[k]  <= ge ? NUM_W_P'(remx - shd) : rem_in;
                den_reg[k]  <= den_in;
                quo_reg[k]  <= quo_in | (QUO_W_P'(ge) << (QUO_W_P - 1 - k));
                side_reg[k] <= side_i;
            end
        end
    end

    assign quo      = quo_reg[QUO_W_P-1];
    assign side_out = side_reg[QUO_W_P-1];

endmodule

### hw/rtl/rgb_to_hsv_8bit.sv
// RGB to HSV converter, 8 bits per channel. One pixel transfer is taken per
// clock while s_tready is high, and one HSV transfer comes out per pixel, in
// order. The pipeline has two front stages (max/min and chroma, then the
// scaled numerators), eight restoring-divider stages that each settle one
// quotient bit, and an output register. The divider depth sets the latency;
// throughput is one pixel per clock whenever the result side keeps m_tready
// high. Each stage holds its own valid bit and loads whenever it is empty or
// the stage after it moves, so bubbles close up under back-pressure and a
// stalled result never blocks earlier stages that still have room.
// Value is the largest channel; saturation is floor(255 * chroma / value),
// zero for black; hue is 0/85/171 for a red/green/blue maximum (red, then
// green, wins ties) plus 43 * difference / chroma truncated toward zero,
// wrapping mod 256, and is zero for grey and black pixels.
module rgb_to_hsv_8bit
    import rthsv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // pixel in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red_in [7:0], green_in [15:8], blue_in [23:16]
    // HSV out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // hue_out [7:0], sat_out [15:8], val_out [23:16]
);

    localparam int FRONT_N = 2;                    // front stages
    localparam int NSTG    = FRONT_N + QUO_W + 1;  // total pipeline stages
    localparam int OUT_IDX = NSTG - 1;

    logic [NSTG-1:0] v_reg, v_next;   // per-stage valid
    logic [NSTG:0]   en;              // per-stage load enable

    // front outputs
    logic [NUM_W-1:0] sat_num, hue_num;
    logic [PIX_W-1:0] sat_den, hue_den;
    hue_side_t        front_side;

    // divider outputs
    logic [QUO_W-1:0] sat_q, hue_q;
    logic [PIX_W-1:0] val_d;
    hue_side_t        side_d;

    logic [PIX_W-1:0] hue_next, sat_next, base;
    logic [PIX_W-1:0] hue_reg, sat_reg, val_reg;

    // A stage may load when it is empty or its contents move on.
    always_comb begin
        en[NSTG] = m_tready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_comb begin
        v_next[0] = en[0] ? s_tvalid : v_reg[0];
        for (int k = 1; k < NSTG; k++) begin
            v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[OUT_IDX];

    rthsv_front u_front (
        .aclk     (aclk),
        .en       (en[FRONT_N-1:0]),
        .red      (s_tdata[7:0]),
        .green    (s_tdata[15:8]),
        .blue     (s_tdata[23:16]),
        .sat_num  (sat_num),
        .sat_den  (sat_den),
        .hue_num  (hue_num),
        .hue_den  (hue_den),
        .hue_side (front_side)
    );

    // saturation: 255 * chroma / value, value rides along as sideband
    rthsv_div #(
        .QUO_W_P (QUO_W),
        .NUM_W_P (NUM_W),
        .DEN_W_P (PIX_W),
        .SIDE_W  (PIX_W)
    ) u_div_sat (
        .aclk     (aclk),
        .en       (en[FRONT_N+QUO_W-1:FRONT_N]),
        .num      (sat_num),
        .den      (sat_den),
        .side_in  (sat_den),
        .quo      (sat_q),
        .side_out (val_d)
    );

    // hue offset magnitude: 43 * |diff| / chroma, at most 43
    rthsv_div #(
        .QUO_W_P (QUO_W),
        .NUM_W_P (NUM_W),
        .DEN_W_P (PIX_W),
        .SIDE_W  ($bits(hue_side_t))
    ) u_div_hue (
        .aclk     (aclk),
        .en       (en[FRONT_N+QUO_W-1:FRONT_N]),
        .num      (hue_num),
        .den      (hue_den),
        .side_in  (front_side),
        .quo      (hue_q),
        .side_out (side_d)
    );

    // Final stage: add signed offset to the sector base, force the
    // black and grey cases.
    always_comb begin
        case (side_d.sel)
            SEL_R:   base = '0;
            SEL_G:   base = PIX_W'(HUE_BASE_G);
            SEL_B:   base = PIX_W'(HUE_BASE_B);
            default: base = '0;
        endcase
        if (side_d.hue_zero) begin
            hue_next = '0;
        end else if (side_d.neg) begin
            hue_next = base - hue_q;
        end else begin
            hue_next = base + hue_q;
        end
        // divide by zero value: black pixel
        sat_next = (val_d == '0) ? '0 : sat_q;
    end

    always_ff @(posedge aclk) begin
        if (en[OUT_IDX]) begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            val_reg <= val_d;
        end
    end

    assign m_tdata = {val_reg, sat_reg, hue_reg};

endmodule

### hw/rtl/rthsv_checker.sv
`include "rgb_to_hsv_8bit_defines.svh"

module rthsv_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // a stalled result transfer holds
    `RTHSV_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

    // nothing comes out in the first cycle after reset
    `RTHSV_ASSERT_NOW(a_reset_empty, !$past(aresetn), !m_tvalid, "result valid right after reset")

    // black pixel: hue and saturation are zero
    `RTHSV_ASSERT_NOW(a_black, m_tvalid && m_tdata[23:16] == 8'd0, m_tdata[15:0] == 16'd0, "black pixel with nonzero hue or sat")

    // zero saturation means grey, so hue is zero
    `RTHSV_ASSERT_NOW(a_grey, m_tvalid && m_tdata[15:8] == 8'd0, m_tdata[7:0] == 8'd0, "grey pixel with nonzero hue")

endmodule

bind rgb_to_hsv_8bit rthsv_checker u_rthsv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
